@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros included by the writer RTL.
// Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ hdl/egnw_pkg.sv @@
// ----------------------------------------------------------------------------
// egnw_pkg
// Types, widths and codes of the Exp-Golomb NAL unit writer.
// ----------------------------------------------------------------------------
package egnw_pkg;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 64;
    localparam int WIDTH_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 16;
    localparam int SE_W     = 32;
    localparam int CODE_W   = SE_W + 1;
    localparam int LEN_W    = 6;
    localparam int IDX_W    = $clog2(VALUE_W);
    localparam int FILL_W   = 3;
    localparam int ZRUN_W   = 2;

    // Raw byte limit per unit
    localparam int RAW_LIMIT = 512;
    localparam int RAW_W     = $clog2(RAW_LIMIT + 1);
    localparam int HDR_BYTES = 2;

    // Request types
    localparam logic [REQ_W-1:0] REQ_FIXED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SE    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TRAIL = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DATA  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    // Constants
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'd512;
    localparam logic [VALUE_W-1:0] UE_MAX          = 64'd4294967294;
    localparam logic [SE_W-1:0]    SE_MIN          = 32'h8000_0000;
    localparam logic [BYTE_W-1:0]  EMU_BYTE        = 8'h03;
    localparam logic [BYTE_W-1:0]  ESC_MAX         = 8'd3;
    localparam logic [BYTE_W-1:0]  TOP_BIT         = 8'h80;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH       = 7'd64;
    localparam logic [ZRUN_W-1:0]  ZRUN_MAX        = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

endpackage

@@ hdl/exp_golomb_nal_writer_top.sv @@
// Output: a completed byte waits in the pending register, then moves to the m_ output
//   register once that is free. One bit per cycle from a single-bit shifter while no
//   completed byte waits; a ue/se code first has its length counted, then its bits placed.
// Each completed byte, each inserted 0x03 and each stall on m_ready holds the shifter
//   while the pending byte waits.
// Reset: aresetn is synchronous; it empties the unit and sets out_limit to 512.
// ----------------------------------------------------------------------------
// exp_golomb_nal_writer_top
// Packs fixed, ue and se syntax elements MSB first into NAL unit bytes and
// inserts emulation-prevention bytes after the two-byte header.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module exp_golomb_nal_writer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [egnw_pkg::REQ_W-1:0]      s_req_type,
    input  logic [egnw_pkg::VALUE_W-1:0]    s_value,
    input  logic [egnw_pkg::WIDTH_W-1:0]    s_width,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [egnw_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                            m_last,
    output logic [egnw_pkg::STATUS_W-1:0]   m_status,
    input  logic                            cfg_we,
    input  logic [egnw_pkg::LIMIT_W-1:0]    cfg_wdata
);
    import egnw_pkg::*;

    // Control state
    state_t                 state_reg, state_next;
    logic [LIMIT_W-1:0]     out_limit_reg, out_limit_next;
    logic [BYTE_W-1:0]      partial_reg, partial_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [RAW_W-1:0]       raw_count_reg, raw_count_next;
    logic [LIMIT_W-1:0]     out_count_reg, out_count_next;
    logic [ZRUN_W-1:0]      zero_run_reg, zero_run_next;
    logic                   unit_failed_reg, unit_failed_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload
    logic [VALUE_W-1:0]     data_reg, data_next;
    logic [CODE_W-1:0]      scan_reg, scan_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       zero_cnt_reg, zero_cnt_next;
    logic [WIDTH_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic                   pend_err_reg, pend_err_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [BYTE_W-1:0]      pend_byte_reg, pend_byte_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   pend_esc_reg, pend_esc_next;
    logic                   pend_hdr_reg, pend_hdr_next;
    logic                   pend_clear_reg, pend_clear_next;
    logic [BYTE_W-1:0]      m_out_byte_reg, m_out_byte_next;
    logic                   m_last_reg, m_last_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    // Datapath helpers
    logic                   out_load;
    logic                   unit_clear;
    logic [WIDTH_W-1:0]     fixed_n;
    logic [SE_W-1:0]        se_raw;
    logic [SE_W-1:0]        se_mag;
    logic                   se_neg;
    logic [CODE_W-1:0]      code;
    logic                   range_err;
    logic [IDX_W-1:0]       bit_idx;
    logic                   cur_bit;
    logic                   last_bit;
    logic [BYTE_W-1:0]      new_partial;
    logic [BYTE_W-1:0]      trail_byte;
    logic [BYTE_W-1:0]      cand_byte;
    logic                   cand_esc;
    logic                   raw_full;

    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !pend_valid_reg;

    // Clamp fixed width, build the ue or se code number plus one
    assign fixed_n   = (s_width > MAX_WIDTH) ? MAX_WIDTH : s_width;
    assign se_raw    = s_value[SE_W-1:0];
    assign se_neg    = se_raw[SE_W-1] || (se_raw == '0);
    assign se_mag    = '0 - se_raw;
    assign code      = (s_req_type == REQ_UE) ? ({1'b0, se_raw} + CODE_W'(1))
                     : (se_neg ? {se_mag, 1'b1} : {se_raw, 1'b0});
    assign range_err = (s_req_type == REQ_UE) ? (s_value > UE_MAX) : (se_raw == SE_MIN);

    // Current bit: prefix zeros first, then data bits MSB first
    assign bit_idx     = IDX_W'(bit_cnt_reg - WIDTH_W'(1));
    assign cur_bit     = (zero_cnt_reg != '0) ? 1'b0 : data_reg[bit_idx];
    assign last_bit    = (zero_cnt_reg == '0) && (bit_cnt_reg == WIDTH_W'(1));
    assign new_partial = partial_reg | (cur_bit ? (TOP_BIT >> fill_reg) : '0);
    assign trail_byte  = partial_reg | (TOP_BIT >> fill_reg);
    assign raw_full    = raw_count_reg >= RAW_W'(RAW_LIMIT);

    // Escape decision for the byte about to complete
    assign cand_byte = (state_reg == ST_SHIFT) ? new_partial : trail_byte;
    assign cand_esc  = (raw_count_reg >= RAW_W'(HDR_BYTES)) && (zero_run_reg == ZRUN_MAX)
                     && (cand_byte <= ESC_MAX);

    always_comb begin
        state_next       = state_reg;
        out_limit_next   = out_limit_reg;
        partial_next     = partial_reg;
        fill_next        = fill_reg;
        raw_count_next   = raw_count_reg;
        out_count_next   = out_count_reg;
        zero_run_next    = zero_run_reg;
        unit_failed_next = unit_failed_reg;
        pend_valid_next  = pend_valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        data_next        = data_reg;
        scan_next        = scan_reg;
        len_next         = len_reg;
        zero_cnt_next    = zero_cnt_reg;
        bit_cnt_next     = bit_cnt_reg;
        pend_err_next    = pend_err_reg;
        pend_status_next = pend_status_reg;
        pend_byte_next   = pend_byte_reg;
        pend_last_next   = pend_last_reg;
        pend_esc_next    = pend_esc_reg;
        pend_hdr_next    = pend_hdr_reg;
        pend_clear_next  = pend_clear_reg;
        m_out_byte_next  = m_out_byte_reg;
        m_last_next      = m_last_reg;
        m_status_next    = m_status_reg;
        unit_clear       = 1'b0;

        // Take a register write
        if (cfg_we) begin
            out_limit_next = cfg_wdata;
        end

        // Drain the pending byte or error into the output register
        if (pend_valid_reg && out_load) begin
            m_valid_next = 1'b1;
            if (pend_err_reg || (out_count_reg >= out_limit_reg)) begin
                m_out_byte_next  = '0;
                m_last_next      = 1'b1;
                m_status_next    = pend_err_reg ? pend_status_reg : STAT_LIMIT;
                unit_failed_next = 1'b1;
                pend_valid_next  = 1'b0;
                unit_clear       = pend_clear_reg;
            end else if (pend_esc_reg) begin
                m_out_byte_next = EMU_BYTE;
                m_last_next     = 1'b0;
                m_status_next   = STAT_DATA;
                out_count_next  = out_count_reg + LIMIT_W'(1);
                zero_run_next   = '0;
                pend_esc_next   = 1'b0;
            end else begin
                m_out_byte_next = pend_byte_reg;
                m_last_next     = pend_last_reg;
                m_status_next   = STAT_DATA;
                out_count_next  = out_count_reg + LIMIT_W'(1);
                if (!pend_hdr_reg) begin
                    if (pend_byte_reg != '0) begin
                        zero_run_next = '0;
                    end else if (zero_run_reg != ZRUN_MAX) begin
                        zero_run_next = zero_run_reg + ZRUN_W'(1);
                    end
                end
                pend_valid_next = 1'b0;
                unit_clear      = pend_clear_reg;
            end
        end

        case (state_reg)
            // Accept a request and set up the bit sequence
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_req_type)
                        REQ_TRAIL: begin
                            if (unit_failed_reg) begin
                                unit_clear = 1'b1;
                            end else begin
                                pend_valid_next = 1'b1;
                                pend_clear_next = 1'b1;
                                pend_esc_next   = 1'b0;
                                if (raw_full) begin
                                    pend_err_next    = 1'b1;
                                    pend_status_next = STAT_LIMIT;
                                end else if (raw_count_reg == '0) begin
                                    pend_err_next    = 1'b1;
                                    pend_status_next = STAT_SHORT;
                                end else begin
                                    pend_err_next  = 1'b0;
                                    pend_byte_next = trail_byte;
                                    pend_last_next = 1'b1;
                                    pend_esc_next  = cand_esc;
                                    pend_hdr_next  = raw_count_reg < RAW_W'(HDR_BYTES);
                                    raw_count_next = raw_count_reg + RAW_W'(1);
                                end
                            end
                        end
                        REQ_FIXED: begin
                            if (!unit_failed_reg && (fixed_n != '0)) begin
                                data_next     = s_value;
                                bit_cnt_next  = fixed_n;
                                zero_cnt_next = '0;
                                state_next    = ST_SHIFT;
                            end
                        end
                        REQ_UE, REQ_SE: begin
                            if (!unit_failed_reg) begin
                                if (range_err) begin
                                    pend_valid_next  = 1'b1;
                                    pend_err_next    = 1'b1;
                                    pend_status_next = STAT_RANGE;
                                    pend_clear_next  = 1'b0;
                                    pend_esc_next    = 1'b0;
                                end else begin
                                    data_next  = VALUE_W'(code);
                                    scan_next  = code;
                                    len_next   = '0;
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Count the code length one bit per cycle
            ST_SCAN: begin
                if (scan_reg != '0) begin
                    scan_next = scan_reg >> 1;
                    len_next  = len_reg + LEN_W'(1);
                end else begin
                    zero_cnt_next = len_reg - LEN_W'(1);
                    bit_cnt_next  = WIDTH_W'(len_reg);
                    state_next    = ST_SHIFT;
                end
            end

            // Place one bit per cycle, hold while a byte waits
            ST_SHIFT: begin
                if (!pend_valid_reg) begin
                    if (unit_failed_reg || (bit_cnt_reg == '0)) begin
                        state_next = ST_IDLE;
                    end else if (raw_full) begin
                        pend_valid_next  = 1'b1;
                        pend_err_next    = 1'b1;
                        pend_status_next = STAT_LIMIT;
                        pend_clear_next  = 1'b0;
                        pend_esc_next    = 1'b0;
                    end else begin
                        if (zero_cnt_reg != '0) begin
                            zero_cnt_next = zero_cnt_reg - LEN_W'(1);
                        end else begin
                            bit_cnt_next = bit_cnt_reg - WIDTH_W'(1);
                        end
                        if (last_bit) begin
                            state_next = ST_IDLE;
                        end
                        fill_next = fill_reg + FILL_W'(1);
                        if (fill_reg == '1) begin
                            partial_next    = '0;
                            pend_valid_next = 1'b1;
                            pend_err_next   = 1'b0;
                            pend_byte_next  = new_partial;
                            pend_last_next  = 1'b0;
                            pend_esc_next   = cand_esc;
                            pend_hdr_next   = raw_count_reg < RAW_W'(HDR_BYTES);
                            pend_clear_next = 1'b0;
                            raw_count_next  = raw_count_reg + RAW_W'(1);
                        end else begin
                            partial_next = new_partial;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a new unit
        if (unit_clear) begin
            partial_next     = '0;
            fill_next        = '0;
            raw_count_next   = '0;
            out_count_next   = '0;
            zero_run_next    = '0;
            unit_failed_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_limit_reg   <= OUT_LIMIT_RESET;
            partial_reg     <= '0;
            fill_reg        <= '0;
            raw_count_reg   <= '0;
            out_count_reg   <= '0;
            zero_run_reg    <= '0;
            unit_failed_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            out_limit_reg   <= out_limit_next;
            partial_reg     <= partial_next;
            fill_reg        <= fill_next;
            raw_count_reg   <= raw_count_next;
            out_count_reg   <= out_count_next;
            zero_run_reg    <= zero_run_next;
            unit_failed_reg <= unit_failed_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        data_reg        <= data_next;
        scan_reg        <= scan_next;
        len_reg         <= len_next;
        zero_cnt_reg    <= zero_cnt_next;
        bit_cnt_reg     <= bit_cnt_next;
        pend_err_reg    <= pend_err_next;
        pend_status_reg <= pend_status_next;
        pend_byte_reg   <= pend_byte_next;
        pend_last_reg   <= pend_last_next;
        pend_esc_reg    <= pend_esc_next;
        pend_hdr_reg    <= pend_hdr_next;
        pend_clear_reg  <= pend_clear_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_last_reg      <= m_last_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;
    assign m_status   = m_status_reg;

    // Raw byte count never passes the limit
    `ASSERT_NEVER(a_raw_bound, aclk, aresetn, raw_count_reg > RAW_W'(RAW_LIMIT))
    // Zero run saturates at two
    `ASSERT_NEVER(a_zrun_bound, aclk, aresetn, zero_run_reg > ZRUN_MAX)
    // Error results are zero bytes that close the unit
    `ASSERT_PROP(a_err_form, aclk, aresetn,
        (m_valid_reg && (m_status_reg != STAT_DATA)) |-> (m_last_reg && (m_out_byte_reg == '0)))
    // A failed unit stops the shifter on the next cycle
    `ASSERT_PROP(a_fail_stop, aclk, aresetn,
        ((state_reg == ST_SHIFT) && unit_failed_reg && !pend_valid_reg) |=> (state_reg == ST_IDLE))

endmodule

@@ test/tb_exp_golomb_nal_writer_top.sv @@
// ----------------------------------------------------------------------------
// tb_exp_golomb_nal_writer_top
// Sends fixed, ue, se and trailing requests to the NAL unit writer. A
// bit-level shadow of the writer predicts every escaped byte and error. Each
// byte taken from the m_ side is compared with the oldest prediction. Both
// sides stall at random. The output limit is changed between phases, while
// the writer is idle.
// ----------------------------------------------------------------------------
module tb_exp_golomb_nal_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import egnw_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_PAD      = 200;

    // Shadow of the writer: predicts escaped bytes and checks the m_ side
    class nal_byte_tracker;
        typedef struct packed {
            logic [BYTE_W-1:0]   data;
            logic                last;
            logic [STATUS_W-1:0] status;
        } nal_byte_t;

        nal_byte_t          expected_bytes[$];
        logic [BYTE_W-1:0]  partial;
        int unsigned        fill;
        int unsigned        raw_count;
        int unsigned        out_count;
        int unsigned        zero_run;
        bit                 unit_failed;
        logic [LIMIT_W-1:0] out_limit;
        int unsigned        errors;

        function new();
            out_limit = OUT_LIMIT_RESET;
            errors    = 0;
            clear_unit();
        endfunction

        function void clear_unit();
            partial     = '0;
            fill        = 0;
            raw_count   = 0;
            out_count   = 0;
            zero_run    = 0;
            unit_failed = 1'b0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] limit);
            out_limit = limit;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [BYTE_W-1:0] data, logic last,
                                logic [STATUS_W-1:0] status);
            nal_byte_t b;
            b.data   = data;
            b.last   = last;
            b.status = status;
            expected_bytes.push_back(b);
        endfunction

        function void fail_unit(logic [STATUS_W-1:0] status);
            push_byte('0, 1'b1, status);
            unit_failed = 1'b1;
        endfunction

        // Emit one raw byte, with an escape in front when the payload calls for it
        function void emit_byte(logic [BYTE_W-1:0] v, logic last);
            int unsigned idx;
            idx = raw_count;
            raw_count++;
            if (idx >= HDR_BYTES && zero_run >= ZRUN_MAX && v <= ESC_MAX) begin
                if (out_count >= out_limit) begin
                    fail_unit(STAT_LIMIT);
                    return;
                end
                push_byte(EMU_BYTE, 1'b0, STAT_DATA);
                out_count++;
                zero_run = 0;
            end
            if (out_count >= out_limit) begin
                fail_unit(STAT_LIMIT);
                return;
            end
            push_byte(v, last, STAT_DATA);
            out_count++;
            if (idx >= HDR_BYTES) begin
                if (v == '0) begin
                    if (zero_run < ZRUN_MAX) zero_run++;
                end else begin
                    zero_run = 0;
                end
            end
        endfunction

        function void put_bit(logic b);
            if (unit_failed) return;
            if (raw_count >= RAW_LIMIT) begin
                fail_unit(STAT_LIMIT);
                return;
            end
            if (b) partial[7 - fill] = 1'b1;
            fill++;
            if (fill == 8) begin
                logic [BYTE_W-1:0] v;
                v       = partial;
                partial = '0;
                fill    = 0;
                emit_byte(v, 1'b0);
            end
        endfunction

        // Place the low n bits of val, MSB first
        function void put_bits(logic [VALUE_W-1:0] val, int unsigned n);
            for (int unsigned i = n; i > 0 && !unit_failed; i--) put_bit(val[i - 1]);
        endfunction

        // Exp-Golomb code of a code number: len-1 zeros, then code+1 in len bits
        function void put_code(logic [VALUE_W-1:0] code_num);
            logic [VALUE_W-1:0] code;
            logic [VALUE_W-1:0] t;
            int unsigned        len;
            code = code_num + 64'd1;
            t    = code;
            len  = 0;
            while (t != 0) begin
                len++;
                t = t >> 1;
            end
            put_bits('0, len - 1);
            put_bits(code, len);
        endfunction

        // Stop bit, padding and the final byte; then open a new unit
        function void finish_unit();
            logic [BYTE_W-1:0] v;
            if (!unit_failed) begin
                if (raw_count >= RAW_LIMIT) begin
                    fail_unit(STAT_LIMIT);
                end else begin
                    v = partial | (TOP_BIT >> fill);
                    if (raw_count + 1 < HDR_BYTES) fail_unit(STAT_SHORT);
                    else emit_byte(v, 1'b1);
                end
            end
            clear_unit();
        endfunction

        // Predict the bytes of one accepted request
        function void take_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] value,
                                   logic [WIDTH_W-1:0] width);
            logic [SE_W-1:0]    raw;
            logic [SE_W-1:0]    mag;
            logic [VALUE_W-1:0] code_num;
            if (req == REQ_TRAIL) begin
                finish_unit();
                return;
            end
            if (unit_failed) return;
            case (req)
                REQ_FIXED: begin
                    put_bits(value, (width > MAX_WIDTH) ? MAX_WIDTH : width);
                end
                REQ_UE: begin
                    if (value > UE_MAX) fail_unit(STAT_RANGE);
                    else put_code(value);
                end
                default: begin
                    raw = value[SE_W-1:0];
                    if (raw == SE_MIN) begin
                        fail_unit(STAT_RANGE);
                    end else begin
                        if (raw == '0 || raw[SE_W-1]) begin
                            mag      = '0 - raw;
                            code_num = {31'd0, mag, 1'b0};
                        end else begin
                            code_num = {31'd0, raw, 1'b0} - 64'd1;
                        end
                        put_code(code_num);
                    end
                end
            endcase
        endfunction

        // Compare one accepted byte with the oldest prediction
        function void match_byte(logic [BYTE_W-1:0] data, logic last,
                                 logic [STATUS_W-1:0] status);
            nal_byte_t exp_b;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0d status %0d",
                         $time, data, last, status);
                errors++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (data !== exp_b.data || last !== exp_b.last || status !== exp_b.status) begin
                $display("%0t: expected %02h/%0d/%0d, got %02h/%0d/%0d (byte/last/status)",
                         $time, exp_b.data, exp_b.last, exp_b.status, data, last, status);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type = '0;
    logic [VALUE_W-1:0]    s_value    = '0;
    logic [WIDTH_W-1:0]    s_width    = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  m_last;
    logic [STATUS_W-1:0]   m_status;
    logic                  cfg_we     = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wdata  = '0;

    nal_byte_tracker tracker = new();
    int unsigned     idle_pct     = 28;
    int unsigned     items_sent   = 0;
    int unsigned     stall_cycles = 0;

    exp_golomb_nal_writer_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_value    (s_value),
        .s_width    (s_width),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_status   (m_status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Stall the result side at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Check every byte taken from the m_ side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.match_byte(m_out_byte, m_last, m_status);
    end

    // Abort when nothing moves on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request or byte accepted for %0d cycles, %0d bytes pending",
                     $time, WATCHDOG_LIMIT, tracker.pending());
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one request, hold it until accepted, then predict its bytes
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] value,
                                input logic [WIDTH_W-1:0] width);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= value;
        s_width    <= width;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        tracker.take_request(req, value, width);
    endtask

    // Drop valid, wait for every predicted byte, then let the shifter run dry
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.set_limit(limit);
    endtask

    // Draw one syntax element, biased toward zero bytes and small codes
    task automatic pick_element(output logic [REQ_W-1:0] req, output logic [VALUE_W-1:0] value,
                                output logic [WIDTH_W-1:0] width);
        int unsigned r;
        int unsigned k;
        r     = $urandom_range(99);
        k     = $urandom_range(99);
        width = WIDTH_W'($urandom);
        value = {$urandom, $urandom};
        if (r < 40) begin
            req = REQ_FIXED;
            if (k < 70) width = WIDTH_W'($urandom_range(1, 16));
            else if (k < 85) width = WIDTH_W'($urandom_range(17, 64));
            else if (k < 90) width = '0;
            else width = WIDTH_W'($urandom_range(65, 127));
            k = $urandom_range(99);
            if (k < 30) value = '0;
            else if (k < 50) value = VALUE_W'($urandom_range(3));
            else if (k < 60) value = '1;
        end else if (r < 70) begin
            req = REQ_UE;
            if (k < 50) value = VALUE_W'($urandom_range(31));
            else if (k < 80) value = {32'd0, $urandom};
            else if (k < 90) value = UE_MAX;
            else if (k < 95) value = UE_MAX + 64'd1;
        end else if (r < 95) begin
            req = REQ_SE;
            if (k < 40) value[SE_W-1:0] = $urandom_range(40) - 20;
            else if (k < 45) value[SE_W-1:0] = SE_MIN;
        end else begin
            req = REQ_TRAIL;
        end
    endtask

    // One unit: usually a 16-bit header, a few elements and the trailing request
    task automatic send_random_unit(input int unsigned n_elems);
        logic [REQ_W-1:0]   req;
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
        if ($urandom_range(99) >= 15) send_request(REQ_FIXED, {$urandom, $urandom}, 7'd16);
        for (int unsigned k = 0; k < n_elems; k++) begin
            pick_element(req, value, width);
            send_request(req, value, width);
        end
        send_request(REQ_TRAIL, {$urandom, $urandom}, WIDTH_W'($urandom));
    endtask

    // n_fields full 64-bit fields, then the trailing request, to reach or pass the raw byte limit
    task automatic send_long_unit(input int unsigned n_fields);
        for (int unsigned k = 0; k < n_fields; k++)
            send_request(REQ_FIXED, {$urandom, $urandom}, MAX_WIDTH);
        send_request(REQ_TRAIL, '0, '0);
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int unsigned n_items,
                             input int unsigned idle);
        int unsigned stop_at;
        settle();
        write_limit(limit);
        idle_pct = idle;
        stop_at  = items_sent + n_items;
        while (items_sent < stop_at) send_random_unit($urandom_range(1, 8));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Escapes after zero payload bytes, code extremes, width clamping
        send_request(REQ_FIXED, 64'h0, 7'd16);
        send_request(REQ_FIXED, 64'h0, 7'd16);
        send_request(REQ_FIXED, 64'h01, 7'd8);
        send_request(REQ_FIXED, 64'h00, 7'd8);
        send_request(REQ_FIXED, 64'h00, 7'd8);
        send_request(REQ_FIXED, 64'h03, 7'd8);
        send_request(REQ_FIXED, 64'h000004, 7'd24);
        send_request(REQ_UE, 64'd0, 7'd127);
        send_request(REQ_UE, UE_MAX, 7'd0);
        send_request(REQ_SE, 64'hDEAD_BEEF_0000_0001, 7'd5);
        send_request(REQ_SE, 64'h0000_0000_FFFF_FFFF, 7'd0);
        send_request(REQ_SE, 64'h0000_0000_7FFF_FFFF, 7'd0);
        send_request(REQ_SE, 64'h0000_0000_8000_0001, 7'd0);
        send_request(REQ_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        send_request(REQ_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd100);
        send_request(REQ_FIXED, 64'hA5A5_5A5A_0F0F_F0F0, 7'd127);
        send_request(REQ_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, MAX_WIDTH);
        send_request(REQ_TRAIL, '1, '1);
        // Unit with no complete byte
        send_request(REQ_TRAIL, '0, '0);
        // Range errors; drop what follows in the unit
        send_request(REQ_FIXED, 64'h40, 7'd8);
        send_request(REQ_SE, 64'hFFFF_FFFF_8000_0000, 7'd0);
        send_request(REQ_UE, 64'd5, 7'd0);
        send_request(REQ_TRAIL, '0, '0);
        send_request(REQ_UE, 64'h0000_0001_0000_0000, 7'd0);
        send_request(REQ_TRAIL, '0, '0);

        // Raw limit: passed inside a field, then hit exactly at the trailing request
        settle();
        write_limit(16'hFFFF);
        send_long_unit(66);
        send_long_unit(64);

        run_phase(16'd2, 30, 28);
        run_phase(16'd7, 30, 28);
        run_phase(OUT_LIMIT_RESET, 60, 0);
        run_phase(16'd20, 30, 28);
        run_phase(LIMIT_W'($urandom_range(8, 60)), 30, 28);
        run_phase(16'd45, 30, 28);

        settle();
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/egnw_pkg.sv
hdl/exp_golomb_nal_writer_top.sv
test/tb_exp_golomb_nal_writer_top.sv
